// ----- design/mfi_pkg.sv -----
// Shared constants and register codes for the money flow index block.
// No dependencies; imported by mfi_div, money_flow_index_window and the testbench.
package mfi_pkg;

	localparam int SUM_BITS   = 64;
	localparam int FS_BITS    = 7;
	localparam int WIN_BITS   = 9;
	localparam int SEEN_BITS  = 9;
	localparam int FRAC_BITS  = 17;
	localparam int RATIO_BITS = SUM_BITS + FS_BITS;
	localparam int DIV_STEPS  = 16;
	localparam int STEP_BITS  = 4;
	localparam int OUT_TDATA_BITS = ((FRAC_BITS + 7) / 8) * 8;

	localparam logic [WIN_BITS-1:0]  WIN_RESET  = 9'd14;
	localparam logic [FS_BITS-1:0]   FS_RESET   = 7'd100;
	localparam logic [FS_BITS-1:0]   MFI_SCALE  = 7'd100;
	localparam logic [SEEN_BITS-1:0] SEEN_MAX   = 9'd511;
	localparam logic [FRAC_BITS-1:0] FRAC_ONE   = 17'd65536;

	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = WIN_BITS;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FULL_SCALE    = 1'd1;

endpackage

// ----- design/mfi_ring.sv -----
// Flow ring: single-port-write, single-port-read memory with registered read data.
// Depends on nothing; sized by the top level.
module mfi_ring #(
	parameter int DEPTH     = 256,
	parameter int ADDR_BITS = 8,
	parameter int DATA_BITS = 57
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [DATA_BITS-1:0] wr_data,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output logic [DATA_BITS-1:0] rd_data
);

	logic [DATA_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- design/mfi_div.sv -----
// Ratio unit: 65536 * 100 * pos / ((pos + neg) * fs), clamped to 65536; zero when both sums are zero.
// Restoring division, one quotient bit per cycle. Uses mfi_pkg.
module mfi_div import mfi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [SUM_BITS-1:0]  pos_sum,
	input  logic [SUM_BITS-1:0]  neg_sum,
	input  logic [FS_BITS-1:0]   full_scale,
	output logic                 done,
	output logic [FRAC_BITS-1:0] quotient
);

	typedef enum logic [3:0] {
		D_IDLE = 4'b0001,
		D_MUL  = 4'b0010,
		D_CHK  = 4'b0100,
		D_STEP = 4'b1000
	} div_state_t;

	div_state_t              state_q;
	logic [STEP_BITS-1:0]    step_q;
	logic                    done_q;
	logic [FRAC_BITS-1:0]    quot_q;
	logic [SUM_BITS-1:0]     pos_q;
	logic [SUM_BITS-1:0]     total_q;
	logic [FS_BITS-1:0]      fs_q;
	logic [RATIO_BITS-1:0]   num_q;
	logic [RATIO_BITS-1:0]   den_q;
	logic                    zero_q;
	logic [RATIO_BITS:0]     shifted;
	logic                    fits;

	assign shifted = {num_q, 1'b0};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_MUL;
					end
				end
				D_MUL: begin
					state_q <= D_CHK;
				end
				D_CHK: begin
					step_q <= '0;
					if (zero_q || num_q >= den_q) begin
						state_q <= D_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= D_STEP;
					end
				end
				D_STEP: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_BITS'(DIV_STEPS - 1)) begin
						state_q <= D_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			D_IDLE: begin
				pos_q   <= pos_sum;
				total_q <= pos_sum + neg_sum;
				fs_q    <= (full_scale == '0) ? FS_BITS'(1) : full_scale;
			end
			D_MUL: begin
				num_q  <= RATIO_BITS'(pos_q) * RATIO_BITS'(MFI_SCALE);
				den_q  <= RATIO_BITS'(total_q) * RATIO_BITS'(fs_q);
				zero_q <= total_q == '0;
			end
			D_CHK: begin
				if (zero_q) begin
					quot_q <= '0;
				end else if (num_q >= den_q) begin
					quot_q <= FRAC_ONE;
				end else begin
					quot_q <= '0;
				end
			end
			D_STEP: begin
				// The remainder stays below the divisor, so the shifted value fits.
				if (fits) begin
					num_q <= RATIO_BITS'(shifted - {1'b0, den_q});
				end else begin
					num_q <= shifted[RATIO_BITS-1:0];
				end
				quot_q <= {quot_q[FRAC_BITS-2:0], fits};
			end
			default: begin
				quot_q <= quot_q;
			end
		endcase
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// ----- design/money_flow_index_window.sv -----
// Money flow index over a sliding window of candles; one candle per input transfer.
// A candle passes S_TP, S_FLOW and S_UPD; once the window is full it goes on through
// S_RATIO, S_WAIT, where the 16-step divider runs unless the ratio is zero or clamped, and
// S_OUT. One candle is in work at a time; a result still waiting in the output register
// holds the next one back. Reset clears the sums and counters and sets the config
// registers (14, 100); the ring needs no clear. Uses mfi_pkg, mfi_ring and mfi_div.
module money_flow_index_window import mfi_pkg::*; #(
	parameter int MAX_WINDOW  = 256,
	parameter int PRICE_BITS  = 24,
	parameter int VOLUME_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// high_price, low_price, close_price, trade_volume, zero fill
	input  logic [((3 * PRICE_BITS + VOLUME_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// start_series
	input  logic                      s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// mfi_fraction, zero fill
	output logic [OUT_TDATA_BITS-1:0] m_tdata,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int PTR_BITS      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int FLOW_BITS     = PRICE_BITS + VOLUME_BITS;
	localparam int ENTRY_BITS    = FLOW_BITS + 1;
	localparam int TRIPLE_BITS   = PRICE_BITS + 2;
	// floor(x / 3) as (x * ceil(2^K / 3)) >> K, exact for x below 2^(K-1).
	localparam int TP_K          = PRICE_BITS + 3;
	localparam int RECIP_BITS    = TP_K - 1;
	localparam logic [RECIP_BITS-1:0] TP_RECIP =
		RECIP_BITS'(((64'd1 << TP_K) + 64'd2) / 64'd3);
	localparam int TP_PROD_BITS  = TRIPLE_BITS + RECIP_BITS;
	localparam logic [WIN_BITS-1:0] MAX_WIN = WIN_BITS'(MAX_WINDOW);
	localparam int ADDR_WORK_BITS = PTR_BITS + 2;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_TP    = 7'b0000010,
		S_FLOW  = 7'b0000100,
		S_UPD   = 7'b0001000,
		S_RATIO = 7'b0010000,
		S_WAIT  = 7'b0100000,
		S_OUT   = 7'b1000000
	} mfi_state_t;

	mfi_state_t             state_q;
	logic [WIN_BITS-1:0]    win_len_q;
	logic [FS_BITS-1:0]     fs_q;
	logic [SUM_BITS-1:0]    pos_q;
	logic [SUM_BITS-1:0]    neg_q;
	logic [PRICE_BITS-1:0]  prev_tp_q;
	logic [SEEN_BITS-1:0]   seen_q;
	logic [PTR_BITS-1:0]    ptr_q;
	logic                   m_tvalid_q;
	logic [FRAC_BITS-1:0]   m_frac_q;
	logic [FRAC_BITS-1:0]   res_q;

	logic [PRICE_BITS-1:0]   high_q, low_q, close_q;
	logic [VOLUME_BITS-1:0]  vol_q;
	logic [TP_PROD_BITS-1:0] tp_prod_q;
	logic [PRICE_BITS-1:0]   tp_q;
	logic [FLOW_BITS-1:0]    flow_q;
	logic                    up_q;
	logic                    evict_q;

	logic                    in_xfer, cfg_xfer, out_free;
	logic [WIN_BITS-1:0]     win;
	logic [TRIPLE_BITS-1:0]  triple;
	logic [PRICE_BITS-1:0]   tp;
	logic [ADDR_WORK_BITS-1:0] old_work;
	logic [PTR_BITS-1:0]     old_addr;
	logic [ENTRY_BITS-1:0]   rd_data;
	logic                    ring_wr;
	logic [SUM_BITS-1:0]     old_flow;
	logic [SUM_BITS-1:0]     pos_sub, neg_sub, pos_add, neg_add;
	logic [SEEN_BITS-1:0]    seen_next;
	logic                    div_done;
	logic [FRAC_BITS-1:0]    div_quot;

	assign s_tready  = state_q == S_IDLE;
	assign cfg_ready = 1'b1;
	assign in_xfer   = s_tvalid && s_tready;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		if (win_len_q == '0) begin
			win = WIN_BITS'(1);
		end else if (win_len_q > MAX_WIN) begin
			win = MAX_WIN;
		end else begin
			win = win_len_q;
		end
	end

	assign triple = TRIPLE_BITS'(high_q) + TRIPLE_BITS'(low_q) + TRIPLE_BITS'(close_q);
	assign tp     = tp_prod_q[TP_K +: PRICE_BITS];

	// Oldest entry of the window sits win places behind the write pointer.
	always_comb begin
		old_work = ADDR_WORK_BITS'(ptr_q) + ADDR_WORK_BITS'(MAX_WINDOW)
			- ADDR_WORK_BITS'(win);
		if (old_work >= ADDR_WORK_BITS'(MAX_WINDOW)) begin
			old_work = old_work - ADDR_WORK_BITS'(MAX_WINDOW);
		end
		old_addr = old_work[PTR_BITS-1:0];
	end

	assign ring_wr  = (state_q == S_UPD) && (seen_q != '0);
	assign old_flow = SUM_BITS'(rd_data[FLOW_BITS-1:0]);
	assign pos_sub  = (evict_q && rd_data[FLOW_BITS])  ? old_flow : '0;
	assign neg_sub  = (evict_q && !rd_data[FLOW_BITS]) ? old_flow : '0;
	assign pos_add  = up_q  ? SUM_BITS'(flow_q) : '0;
	assign neg_add  = !up_q ? SUM_BITS'(flow_q) : '0;
	assign seen_next = (seen_q == SEEN_MAX) ? seen_q : seen_q + 1'b1;

	mfi_ring #(
		.DEPTH     (MAX_WINDOW),
		.ADDR_BITS (PTR_BITS),
		.DATA_BITS (ENTRY_BITS)
	) u_ring (
		.clk     (clk),
		.wr_en   (ring_wr),
		.wr_addr (ptr_q),
		.wr_data ({up_q, flow_q}),
		.rd_en   (state_q == S_FLOW),
		.rd_addr (old_addr),
		.rd_data (rd_data)
	);

	mfi_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (state_q == S_RATIO),
		.pos_sum    (pos_q),
		.neg_sum    (neg_q),
		.full_scale (fs_q),
		.done       (div_done),
		.quotient   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			win_len_q  <= WIN_RESET;
			fs_q       <= FS_RESET;
			pos_q      <= '0;
			neg_q      <= '0;
			prev_tp_q  <= '0;
			seen_q     <= '0;
			ptr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_xfer) begin
				unique case (cfg_index)
					REG_WINDOW_LENGTH: begin
						win_len_q <= cfg_data;
					end
					REG_FULL_SCALE: begin
						fs_q <= cfg_data[FS_BITS-1:0];
					end
					default: begin
						fs_q <= fs_q;
					end
				endcase
			end
			// A window length write and a series start both drop the history.
			if ((cfg_xfer && cfg_index == REG_WINDOW_LENGTH) || (in_xfer && s_tuser)) begin
				pos_q     <= '0;
				neg_q     <= '0;
				prev_tp_q <= '0;
				seen_q    <= '0;
				ptr_q     <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_TP;
					end
				end
				S_TP: begin
					state_q <= S_FLOW;
				end
				S_FLOW: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (seen_q != '0) begin
						pos_q <= pos_q - pos_sub + pos_add;
						neg_q <= neg_q - neg_sub + neg_add;
						ptr_q <= (ptr_q == PTR_BITS'(MAX_WINDOW - 1)) ? '0 : ptr_q + 1'b1;
					end
					prev_tp_q <= tp_q;
					seen_q    <= seen_next;
					if ((WIN_BITS + 1)'(seen_next) >= (WIN_BITS + 1)'(win) + 1'b1) begin
						state_q <= S_RATIO;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RATIO: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			high_q  <= s_tdata[0 +: PRICE_BITS];
			low_q   <= s_tdata[PRICE_BITS +: PRICE_BITS];
			close_q <= s_tdata[2 * PRICE_BITS +: PRICE_BITS];
			vol_q   <= s_tdata[3 * PRICE_BITS +: VOLUME_BITS];
		end
		if (state_q == S_TP) begin
			tp_prod_q <= TP_PROD_BITS'(triple) * TP_PROD_BITS'(TP_RECIP);
		end
		if (state_q == S_FLOW) begin
			tp_q    <= tp;
			flow_q  <= FLOW_BITS'(tp) * FLOW_BITS'(vol_q);
			up_q    <= tp > prev_tp_q;
			evict_q <= (seen_q != '0) && ((seen_q - 1'b1) >= SEEN_BITS'(win));
		end
		if (state_q == S_WAIT && div_done) begin
			res_q <= div_quot;
		end
		if (state_q == S_OUT && out_free) begin
			m_frac_q <= res_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_BITS'(m_frac_q);

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for money_flow_index_window: directed candles, then random series.
// Results are checked against an in-module money flow index predictor or a known value.
// Depends on mfi_pkg and the RTL of the block.
module tb_top;
	import mfi_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF       = 4;
	localparam int PRICE_W        = 24;
	localparam int VOLUME_W       = 32;
	localparam int CANDLE_BITS    = 3 * PRICE_W + VOLUME_W;
	localparam int RING_DEPTH     = 256;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PRINT_CAP      = 50;

	typedef struct packed {
		logic                start;
		logic [PRICE_W-1:0]  hi_px;
		logic [PRICE_W-1:0]  lo_px;
		logic [PRICE_W-1:0]  cl_px;
		logic [VOLUME_W-1:0] vol;
	} candle_t;

	// Setup rows write both registers; known rows carry a result read off directly.
	typedef enum logic [1:0] {ROW_SETUP, ROW_PREDICT, ROW_KNOWN} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		candle_t                cd;
		logic [CFG_DATA_BITS-1:0] win;
		logic [CFG_DATA_BITS-1:0] fs;
		logic [FRAC_BITS-1:0]   known;
	} stim_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	// high_price, low_price, close_price, trade_volume
	logic [CANDLE_BITS-1:0]    s_tdata;
	// start_series
	logic                      s_tuser;
	logic                      m_tvalid;
	logic                      m_tready;
	// mfi_fraction, zero fill
	logic [OUT_TDATA_BITS-1:0] m_tdata;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	// Predictor state.
	logic [56:0]          mf_ring [RING_DEPTH];
	logic [63:0]          up_total;
	logic [63:0]          down_total;
	logic [PRICE_W-1:0]   last_typical;
	logic [8:0]           series_count;
	logic [7:0]           slot;
	logic [WIN_BITS-1:0]  win_cfg;
	logic [FS_BITS-1:0]   scale_cfg;

	logic [FRAC_BITS-1:0] mfi_due [$];
	stim_row_t            dir_rows [$];
	int                   src_idle_pct;
	int                   snk_idle_pct;
	int                   fail_count;
	int                   stall_cycles;
	int                   walk_base;
	candle_t              prev_candle;
	logic [FRAC_BITS-1:0] want;

	money_flow_index_window dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
	end

	task automatic note_mismatch(input string msg);
		if (fail_count < PRINT_CAP)
			$display("MISMATCH at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic void add_row(input stim_row_t r);
		dir_rows = {dir_rows, r};
	endfunction

	function automatic void clear_history();
		up_total = '0;
		down_total = '0;
		last_typical = '0;
		series_count = '0;
		slot = '0;
	endfunction

	function automatic logic [FRAC_BITS-1:0] mfi_ratio();
		logic [63:0]  total;
		logic [127:0] num;
		logic [127:0] den;
		logic [FS_BITS-1:0] fs;
		total = up_total + down_total;
		fs = (scale_cfg == '0) ? FS_BITS'(1) : scale_cfg;
		if (total == '0)
			return '0;
		num = {64'b0, up_total} * MFI_SCALE;
		den = {64'b0, total} * fs;
		if (num >= den)
			return FRAC_ONE;
		return 17'((num << 16) / den);
	endfunction

	// Advances the predictor by one accepted candle.
	function automatic void step_mfi(input candle_t cd, output logic got,
		output logic [FRAC_BITS-1:0] frac);
		logic [PRICE_W+1:0] price_sum;
		logic [PRICE_W-1:0] tp;
		logic [55:0]        flow;
		logic               rising;
		logic [8:0]         span;
		logic [7:0]         oldest;
		logic [56:0]        gone;
		span = (win_cfg == '0) ? 9'd1 : (win_cfg > 9'd256) ? 9'd256 : win_cfg;
		if (cd.start)
			clear_history();
		price_sum = cd.hi_px + cd.lo_px + cd.cl_px;
		tp = 24'(price_sum / 3);
		if (series_count >= 9'd1) begin
			flow = 56'(tp) * 56'(cd.vol);
			rising = (tp > last_typical);
			if (9'(series_count - 9'd1) >= span) begin
				// A full window of 256 evicts the slot about to be overwritten.
				oldest = slot - span[7:0];
				gone = mf_ring[oldest];
				if (gone[56])
					up_total = up_total - gone[55:0];
				else
					down_total = down_total - gone[55:0];
			end
			mf_ring[slot] = {rising, flow};
			slot = slot + 8'd1;
			if (rising)
				up_total = up_total + flow;
			else
				down_total = down_total + flow;
		end
		last_typical = tp;
		if (series_count < SEEN_MAX)
			series_count = series_count + 9'd1;
		got = (series_count >= span + 1);
		frac = got ? mfi_ratio() : '0;
	endfunction

	function automatic stim_row_t candle_row(input row_kind_t kind, input logic start,
		input logic [23:0] h, input logic [23:0] l, input logic [23:0] c,
		input logic [31:0] v, input logic [FRAC_BITS-1:0] known);
		stim_row_t r;
		r = '0;
		r.kind = kind;
		r.cd = {start, h, l, c, v};
		r.known = known;
		return r;
	endfunction

	function automatic stim_row_t setup_row(input logic [8:0] win, input logic [8:0] fs);
		stim_row_t r;
		r = '0;
		r.kind = ROW_SETUP;
		r.win = win;
		r.fs = fs;
		return r;
	endfunction

	function automatic logic [23:0] clip_price(input int p);
		if (p < 0)
			return '0;
		if (p > 24'hFFFFFF)
			return 24'hFFFFFF;
		return 24'(p);
	endfunction

	// Mostly a slow price walk with repeats, so rising, falling and flat candles all occur.
	function automatic candle_t next_candle(input bit allow_start);
		candle_t cd;
		int r;
		int rv;
		r = $urandom_range(0, 99);
		rv = $urandom_range(0, 99);
		cd.start = allow_start && ($urandom_range(0, 99) < 3);
		if (r < 20) begin
			cd.hi_px = 24'($urandom);
			cd.lo_px = 24'($urandom);
			cd.cl_px = 24'($urandom);
			walk_base = cd.cl_px;
		end else if (r < 35) begin
			cd.hi_px = prev_candle.hi_px;
			cd.lo_px = prev_candle.lo_px;
			cd.cl_px = prev_candle.cl_px;
		end else begin
			walk_base = clip_price(walk_base + $urandom_range(0, 200) - 100);
			cd.hi_px = clip_price(walk_base + $urandom_range(0, 20));
			cd.lo_px = clip_price(walk_base - $urandom_range(0, 20));
			cd.cl_px = clip_price(walk_base);
		end
		if (rv < 10)
			cd.vol = '0;
		else if (rv < 20)
			cd.vol = '1;
		else if (rv < 50)
			cd.vol = $urandom;
		else
			cd.vol = $urandom_range(1, 100000);
		prev_candle = cd;
		return cd;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic put_candle(input candle_t cd, input logic is_known,
		input logic [FRAC_BITS-1:0] known);
		logic got;
		logic [FRAC_BITS-1:0] frac;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {cd.vol, cd.cl_px, cd.lo_px, cd.hi_px};
		s_tuser <= cd.start;
		do @(posedge clk); while (!s_tready);
		step_mfi(cd, got, frac);
		if (got)
			mfi_due.insert(mfi_due.size(), is_known ? known : frac);
		@(negedge clk);
	endtask

	// Waits until the block is idle so the registers may be written.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (mfi_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Two back-to-back transfers: window length first, then full scale.
	task automatic write_regs(input logic [8:0] win, input logic [8:0] fs);
		cfg_valid <= 1'b1;
		cfg_index <= REG_WINDOW_LENGTH;
		cfg_data <= win;
		do @(posedge clk); while (!cfg_ready);
		win_cfg = win;
		clear_history();
		@(negedge clk);
		cfg_index <= REG_FULL_SCALE;
		cfg_data <= fs;
		do @(posedge clk); while (!cfg_ready);
		scale_cfg = fs[FS_BITS-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_segment(input int count, input bit allow_start,
		input logic [8:0] win);
		int r;
		logic [6:0] fs7;
		r = $urandom_range(0, 99);
		if (r < 20)
			fs7 = 7'd0;
		else if (r < 35)
			fs7 = 7'd1;
		else if (r < 50)
			fs7 = MFI_SCALE;
		else if (r < 65)
			fs7 = 7'd127;
		else
			fs7 = 7'($urandom_range(0, 127));
		settle();
		write_regs(win, {2'($urandom_range(0, 3)), fs7});
		repeat (count) put_candle(next_candle(allow_start), 1'b0, '0);
	endtask

	function automatic logic [8:0] pick_window();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 9'($urandom_range(1, 6));
		if (r < 75)
			return 9'($urandom_range(7, 40));
		if (r < 85)
			return 9'd0;
		if (r < 92)
			return 9'd256;
		return 9'($urandom_range(0, 511));
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (mfi_due.size() == 0) begin
					note_mismatch($sformatf("result 0x%0h with nothing pending", m_tdata));
				end else begin
					want = mfi_due.pop_front();
					if (m_tdata[FRAC_BITS-1:0] != want)
						note_mismatch($sformatf("mfi_fraction %0d, predicted %0d",
							m_tdata[FRAC_BITS-1:0], want));
					if (m_tdata[OUT_TDATA_BITS-1:FRAC_BITS] != '0)
						note_mismatch($sformatf("nonzero fill bits in 0x%0h", m_tdata));
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int ph;
		int seg;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		m_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_WINDOW_LENGTH;
		cfg_data <= '0;
		src_idle_pct = 30;
		snk_idle_pct = 88;
		fail_count = 0;
		stall_cycles = 0;
		walk_base = 1000;
		prev_candle = '0;
		win_cfg = WIN_RESET;
		scale_cfg = FS_RESET;
		clear_history();

		// Window of one: each result follows from the latest flow alone.
		add_row(setup_row(9'd1, 9'd100));
		add_row(candle_row(ROW_PREDICT, 1'b1, 24'd0, 24'd0, 24'd0, 32'd0, '0));
		add_row(candle_row(ROW_KNOWN, 1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
			32'hFFFFFFFF, FRAC_ONE));
		// Equal typical price counts as negative flow.
		add_row(candle_row(ROW_KNOWN, 1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
			32'hFFFFFFFF, 17'd0));
		// Both sums zero.
		add_row(candle_row(ROW_KNOWN, 1'b0, 24'd0, 24'd0, 24'd0,
			32'hFFFFFFFF, 17'd0));
		add_row(candle_row(ROW_KNOWN, 1'b0, 24'd3, 24'd0, 24'd0, 32'd0, 17'd0));
		// Typical price floors to the previous one.
		add_row(candle_row(ROW_KNOWN, 1'b0, 24'd1, 24'd1, 24'd2, 32'd5, 17'd0));
		add_row(candle_row(ROW_KNOWN, 1'b0, 24'd2, 24'd2, 24'd3, 32'd7, FRAC_ONE));
		// A new series in mid-stream gives no result for its first candle.
		add_row(candle_row(ROW_PREDICT, 1'b1, 24'd100, 24'd200, 24'd300,
			32'd1000, '0));
		add_row(candle_row(ROW_KNOWN, 1'b0, 24'd400, 24'd400, 24'd400, 32'd1,
			FRAC_ONE));
		add_row(setup_row(9'd2, 9'd50));
		add_row(candle_row(ROW_PREDICT, 1'b1, 24'd300, 24'd300, 24'd300, 32'd10, '0));
		add_row(candle_row(ROW_PREDICT, 1'b0, 24'd301, 24'd301, 24'd301, 32'd10, '0));
		add_row(candle_row(ROW_PREDICT, 1'b0, 24'd299, 24'd299, 24'd299, 32'd30, '0));
		add_row(candle_row(ROW_PREDICT, 1'b0, 24'd305, 24'd305, 24'd305, 32'd20, '0));
		add_row(candle_row(ROW_PREDICT, 1'b0, 24'd305, 24'd305, 24'd305, 32'd0, '0));
		// Window zero acts as one; full scale masks to zero and acts as one.
		add_row(setup_row(9'd0, 9'h180));
		add_row(candle_row(ROW_PREDICT, 1'b1, 24'd5, 24'd5, 24'd5, 32'd3, '0));
		add_row(candle_row(ROW_KNOWN, 1'b0, 24'd6, 24'd6, 24'd6, 32'd3, FRAC_ONE));
		add_row(candle_row(ROW_KNOWN, 1'b0, 24'd0, 24'd0, 24'd0, 32'hFFFFFFFF,
			17'd0));
		// Oversized window acts as the ring depth.
		add_row(setup_row(9'h1FF, 9'h07F));
		add_row(candle_row(ROW_PREDICT, 1'b1, 24'hFFFFFF, 24'd0, 24'hFFFFFF,
			32'd12345, '0));
		add_row(candle_row(ROW_PREDICT, 1'b0, 24'd0, 24'hFFFFFF, 24'd0,
			32'hFFFFFFFF, '0));
		add_row(candle_row(ROW_PREDICT, 1'b0, 24'h123456, 24'h654321, 24'hABCDEF,
			32'h89ABCDEF, '0));

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_SETUP) begin
				settle();
				write_regs(dir_rows[i].win, dir_rows[i].fs);
			end else begin
				put_candle(dir_rows[i].cd, dir_rows[i].kind == ROW_KNOWN, dir_rows[i].known);
			end
		end

		for (ph = 0; ph < 3; ph++) begin
			src_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 88 : 0;
			snk_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 30 : 0;
			for (seg = 0; seg < 3; seg++)
				random_segment(35, 1'b1, pick_window());
		end
		// One long series fills the full ring so that the oldest slot gets recycled.
		random_segment(300, 1'b0, 9'd256);

		settle();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
